// ----- src/http_start_line_parser_assert.svh -----
// ---------------------------------------------------------------------------
// HTTP start line parser assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef HTTP_START_LINE_PARSER_ASSERT_SVH
`define HTTP_START_LINE_PARSER_ASSERT_SVH

// Same-cycle implication: when ante holds, cons holds at that edge.
`define HSLP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when ante holds, cons holds at the following edge.
`define HSLP_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/hslp_pkg.sv -----
// ---------------------------------------------------------------------------
// HTTP start line parser package
// Types, keyword tables and lookup functions shared by the parser modules.
// ---------------------------------------------------------------------------
package hslp_pkg;

   // Parser phases.
   typedef enum logic [3:0] {
      PHASE_METHOD      = 4'd0,
      PHASE_METHOD_END  = 4'd1,
      PHASE_URI         = 4'd2,
      PHASE_VERSION     = 4'd3,
      PHASE_VERSION_END = 4'd4,
      PHASE_STATUS      = 4'd5,
      PHASE_STATUS_END  = 4'd6,
      PHASE_REASON      = 4'd7,
      PHASE_DONE        = 4'd8,
      PHASE_ERROR       = 4'd9
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_URI    = 2'd1,
      KIND_REASON = 2'd2
   } text_kind_type;

   localparam logic [3:0] METHOD_NONE = 4'd0;
   localparam logic [3:0] METHOD_GET  = 4'd2;

   localparam logic [2:0] VERSION_NONE = 3'd0;
   localparam logic [2:0] VERSION_0_9  = 3'd1;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Longest stored match and the point past which a field is too long.
   localparam int MATCH_BYTES = 8;
   localparam logic [3:0] METHOD_MAX_LEN  = 4'd7;
   localparam logic [3:0] VERSION_MAX_LEN = 4'd8;
   localparam logic [3:0] MATCH_LEN_CAP   = 4'd15;
   localparam logic [3:0] STATUS_DIGITS   = 4'd3;

   // Keywords, first character in the low byte, zero padded.
   localparam int NUM_METHODS  = 9;
   localparam int NUM_VERSIONS = 3;

   localparam logic [63:0] METHOD_TEXT [NUM_METHODS] = '{
      64'h0053_4E4F_4954_504F,   // OPTIONS
      64'h0000_0000_0054_4547,   // GET
      64'h0000_0000_4441_4548,   // HEAD
      64'h0000_0000_5453_4F50,   // POST
      64'h0000_0000_0054_5550,   // PUT
      64'h0000_0048_4354_4150,   // PATCH
      64'h0000_4554_454C_4544,   // DELETE
      64'h0000_0045_4341_5254,   // TRACE
      64'h0054_4345_4E4E_4F43    // CONNECT
   };
   localparam logic [3:0] METHOD_LEN [NUM_METHODS] = '{
      4'd7, 4'd3, 4'd4, 4'd4, 4'd3, 4'd5, 4'd6, 4'd5, 4'd7
   };

   localparam logic [63:0] VERSION_TEXT [NUM_VERSIONS] = '{
      64'h302E_312F_5054_5448,   // HTTP/1.0
      64'h312E_312F_5054_5448,   // HTTP/1.1
      64'h0000_322F_5054_5448    // HTTP/2
   };
   localparam logic [3:0] VERSION_LEN [NUM_VERSIONS] = '{4'd8, 4'd8, 4'd6};

   // Depth of the queue between the classifier and the parser.
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_W = $clog2(QUEUE_DEPTH + 1);

   // One classified byte or restart request.
   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
      logic       is_ws;
      logic       is_lf;
      logic       is_digit;
      logic [3:0] digit;
   } token_type;

   // Method code for an exact keyword match, METHOD_NONE otherwise.
   function automatic logic [3:0] method_lookup(input logic [63:0] text,
                                                input logic [3:0]  len);
      logic [3:0] code;
      code = METHOD_NONE;
      for (int i = NUM_METHODS - 1; i >= 0; i--) begin
         if (len == METHOD_LEN[i] && text == METHOD_TEXT[i]) begin
            code = 4'(i + 1);
         end
      end
      return code;
   endfunction

   // Version code for an exact keyword match, VERSION_NONE otherwise.
   function automatic logic [2:0] version_lookup(input logic [63:0] text,
                                                 input logic [3:0]  len);
      logic [2:0] code;
      code = VERSION_NONE;
      for (int i = NUM_VERSIONS - 1; i >= 0; i--) begin
         if (len == VERSION_LEN[i] && text == VERSION_TEXT[i]) begin
            code = 3'(i + 2);
         end
      end
      return code;
   endfunction

endpackage

// ----- src/hslp_front.sv -----
// ---------------------------------------------------------------------------
// HTTP start line parser front end
// Accepts request transactions and classifies each byte for the parser.
// ---------------------------------------------------------------------------
module hslp_front (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  logic [7:0]            req_data_byte,
   input  logic                  queue_full,
   output logic                  push,
   output hslp_pkg::token_type   push_token
);
   import hslp_pkg::*;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_token.command   = req_command;
      push_token.data_byte = req_data_byte;
      push_token.is_ws     = (req_data_byte == CHAR_SPACE) ||
                             (req_data_byte >= CHAR_TAB && req_data_byte <= CHAR_CR);
      push_token.is_lf     = (req_data_byte == CHAR_LF);
      push_token.is_digit  = (req_data_byte >= CHAR_ZERO && req_data_byte <= CHAR_NINE);
      // ASCII digits carry their value in the low nibble.
      push_token.digit     = req_data_byte[3:0];
   end

endmodule

// ----- src/hslp_queue.sv -----
// ---------------------------------------------------------------------------
// HTTP start line parser token queue
// Small first-in first-out buffer between the classifier and the parser.
// ---------------------------------------------------------------------------
module hslp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  hslp_pkg::token_type   push_token,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output hslp_pkg::token_type   head_token
);
   import hslp_pkg::*;

   `include "http_start_line_parser_assert.svh"

   token_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == QUEUE_COUNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_token = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

   `HSLP_ASSERT_IMP(a_queue_no_overflow, push, !full, "push into a full queue")
   `HSLP_ASSERT_IMP(a_queue_no_underflow, pop, head_valid, "pop from an empty queue")
   `HSLP_ASSERT_NXT(a_queue_count_step, push && !pop, count_ff == $past(count_ff) + 1'b1,
      "queue count did not grow on push")

endmodule

// ----- src/hslp_back.sv -----
// ---------------------------------------------------------------------------
// HTTP start line parser back end
// Runs the start line state machine on classified bytes and holds the result.
// ---------------------------------------------------------------------------
module hslp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data,
   input  logic                  tok_valid,
   input  hslp_pkg::token_type   tok,
   output logic                  tok_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_text_kind,
   output logic [7:0]            rsp_text_byte,
   output logic                  rsp_text_end,
   output logic [3:0]            rsp_method_code,
   output logic [2:0]            rsp_version_code,
   output logic [9:0]            rsp_status_code,
   output logic                  rsp_line_done,
   output logic                  rsp_parse_error
);
   import hslp_pkg::*;

   `include "http_start_line_parser_assert.svh"

   phase_type      phase_ff, phase_in;
   logic           message_type_ff;
   logic [63:0]    match_buffer_ff, match_buffer_in;
   logic [3:0]     match_length_ff, match_length_in;
   logic [3:0]     method_seen_ff, method_seen_in;
   logic [2:0]     version_seen_ff, version_seen_in;
   logic [9:0]     status_value_ff, status_value_in;

   logic           rsp_valid_ff, rsp_valid_in;
   text_kind_type  text_kind_ff, text_kind_in;
   logic [7:0]     text_byte_ff, text_byte_in;
   logic           text_end_ff, text_end_in;

   logic [63:0]    app_buffer;
   logic [3:0]     app_length;
   logic [3:0]     method_hit;
   logic [2:0]     version_hit;
   logic [3:0]     status_count;
   logic [13:0]    status_mac;

   // A token is taken whenever the result register is free or being drained.
   assign tok_pop = tok_valid && (!rsp_valid_ff || !rsp_stall);

   // Keyword buffer with the current byte appended.
   always_comb begin
      app_buffer = match_buffer_ff;
      for (int i = 0; i < MATCH_BYTES; i++) begin
         if (match_length_ff == 4'(i)) begin
            app_buffer[8*i +: 8] = tok.data_byte;
         end
      end
      app_length = (match_length_ff < MATCH_LEN_CAP) ? match_length_ff + 4'd1
                                                     : match_length_ff;
   end

   assign method_hit   = method_lookup(app_buffer, app_length);
   assign version_hit  = version_lookup(app_buffer, app_length);
   assign status_count = match_length_ff + 4'd1;
   assign status_mac   = 14'({status_value_ff, 3'b000}) + 14'({status_value_ff, 1'b0}) +
                         14'(tok.digit);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (tok.command) begin
         phase_in = message_type_ff ? PHASE_VERSION : PHASE_METHOD;
      end else begin
         unique case (phase_ff)
            PHASE_METHOD: begin
               if (method_hit != METHOD_NONE) begin
                  phase_in = PHASE_METHOD_END;
               end else if (tok.is_ws || app_length > METHOD_MAX_LEN) begin
                  phase_in = PHASE_ERROR;
               end
            end
            PHASE_METHOD_END: begin
               phase_in = tok.is_ws ? PHASE_URI : PHASE_ERROR;
            end
            PHASE_URI: begin
               if (tok.is_lf) begin
                  phase_in = (method_seen_ff == METHOD_GET) ? PHASE_DONE : PHASE_ERROR;
               end else if (tok.is_ws) begin
                  phase_in = PHASE_VERSION;
               end
            end
            PHASE_VERSION: begin
               if (version_hit != VERSION_NONE) begin
                  phase_in = message_type_ff ? PHASE_VERSION_END : PHASE_DONE;
               end else if (tok.is_ws || app_length > VERSION_MAX_LEN) begin
                  phase_in = PHASE_ERROR;
               end
            end
            PHASE_VERSION_END: begin
               phase_in = tok.is_ws ? PHASE_STATUS : PHASE_ERROR;
            end
            PHASE_STATUS: begin
               if (!tok.is_digit) begin
                  phase_in = PHASE_ERROR;
               end else if (status_count >= STATUS_DIGITS) begin
                  phase_in = PHASE_STATUS_END;
               end
            end
            PHASE_STATUS_END: begin
               phase_in = tok.is_ws ? PHASE_REASON : PHASE_ERROR;
            end
            PHASE_REASON: begin
               if (tok.is_lf) begin
                  phase_in = PHASE_DONE;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Match state, parsed values and the text byte of this result.
   always_comb begin
      match_buffer_in = match_buffer_ff;
      match_length_in = match_length_ff;
      method_seen_in  = method_seen_ff;
      version_seen_in = version_seen_ff;
      status_value_in = status_value_ff;
      text_kind_in    = KIND_NONE;
      text_byte_in    = 8'd0;
      text_end_in     = 1'b0;
      if (tok.command) begin
         match_buffer_in = '0;
         match_length_in = '0;
         method_seen_in  = METHOD_NONE;
         version_seen_in = VERSION_NONE;
         status_value_in = '0;
      end else begin
         unique case (phase_ff)
            PHASE_METHOD: begin
               if (method_hit != METHOD_NONE) begin
                  method_seen_in  = method_hit;
                  match_buffer_in = '0;
                  match_length_in = '0;
               end else if (tok.is_ws || app_length > METHOD_MAX_LEN) begin
                  match_buffer_in = '0;
                  match_length_in = '0;
               end else begin
                  match_buffer_in = app_buffer;
                  match_length_in = app_length;
               end
            end
            PHASE_URI: begin
               text_kind_in = KIND_URI;
               if (tok.is_lf) begin
                  text_end_in = 1'b1;
                  if (method_seen_ff == METHOD_GET) begin
                     version_seen_in = VERSION_0_9;
                  end
               end else if (tok.is_ws) begin
                  text_end_in     = 1'b1;
                  match_buffer_in = '0;
                  match_length_in = '0;
               end else begin
                  text_byte_in = tok.data_byte;
               end
            end
            PHASE_VERSION: begin
               if (version_hit != VERSION_NONE) begin
                  version_seen_in = version_hit;
                  match_buffer_in = '0;
                  match_length_in = '0;
               end else if (tok.is_ws || app_length > VERSION_MAX_LEN) begin
                  match_buffer_in = '0;
                  match_length_in = '0;
               end else begin
                  match_buffer_in = app_buffer;
                  match_length_in = app_length;
               end
            end
            PHASE_VERSION_END: begin
               if (tok.is_ws) begin
                  match_buffer_in = '0;
                  match_length_in = '0;
                  status_value_in = '0;
               end
            end
            PHASE_STATUS: begin
               if (tok.is_digit) begin
                  status_value_in = status_mac[9:0];
                  if (status_count >= STATUS_DIGITS) begin
                     match_buffer_in = '0;
                     match_length_in = '0;
                  end else begin
                     match_length_in = status_count;
                  end
               end else begin
                  match_buffer_in = '0;
                  match_length_in = '0;
               end
            end
            PHASE_REASON: begin
               text_kind_in = KIND_REASON;
               if (tok.is_lf) begin
                  text_end_in = 1'b1;
               end else begin
                  text_byte_in = tok.data_byte;
               end
            end
            default: begin
               text_kind_in = KIND_NONE;
            end
         endcase
      end
   end

   always_comb begin
      if (tok_pop) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PHASE_METHOD;
         message_type_ff <= 1'b0;
         match_buffer_ff <= '0;
         match_length_ff <= '0;
         method_seen_ff  <= METHOD_NONE;
         version_seen_ff <= VERSION_NONE;
         status_value_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            message_type_ff <= csr_wr_data;
         end
         if (tok_pop) begin
            phase_ff        <= phase_in;
            match_buffer_ff <= match_buffer_in;
            match_length_ff <= match_length_in;
            method_seen_ff  <= method_seen_in;
            version_seen_ff <= version_seen_in;
            status_value_ff <= status_value_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_pop) begin
         text_kind_ff <= text_kind_in;
         text_byte_ff <= text_byte_in;
         text_end_ff  <= text_end_in;
      end
   end

   // Parsed values change only when a token is taken, so they always belong
   // to the result that is on display.
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_text_kind    = text_kind_ff;
   assign rsp_text_byte    = text_byte_ff;
   assign rsp_text_end     = text_end_ff;
   assign rsp_method_code  = method_seen_ff;
   assign rsp_version_code = version_seen_ff;
   assign rsp_status_code  = status_value_ff;
   assign rsp_line_done    = (phase_ff == PHASE_DONE);
   assign rsp_parse_error  = (phase_ff == PHASE_ERROR);

   `HSLP_ASSERT_IMP(a_back_end_has_kind, rsp_valid_ff && text_end_ff,
      text_kind_ff != KIND_NONE, "text end without a text field")
   `HSLP_ASSERT_IMP(a_back_status_count, phase_ff == PHASE_STATUS,
      match_length_ff < STATUS_DIGITS, "status digit count out of range")
   `HSLP_ASSERT_NXT(a_back_restart_clears, tok_pop && tok.command,
      method_seen_ff == METHOD_NONE && status_value_ff == 10'd0,
      "restart left parsed values behind")
   `HSLP_ASSERT_NXT(a_back_phase_holds, !tok_pop, $stable(phase_ff),
      "phase moved without a token")

endmodule

// ----- src/http_start_line_parser.sv -----
// ---------------------------------------------------------------------------
// HTTP start line parser
// Parses an HTTP request line or response status line, one byte per
// transaction, and returns one result transaction for every byte.
// ---------------------------------------------------------------------------
//
//   Channel   Direction   Handshake             Payload
//   req_      in          req_valid/req_stall   command, data byte
//   rsp_      out         rsp_valid/rsp_stall   text, method, version, status, flags
//   csr_      in          csr_wr_en             message type (0 request, 1 response)
//
// Throughput is one byte per cycle while rsp_stall is low: the back end handles one
// token per cycle and its keyword compares finish within that cycle. An accepted byte
// goes into the token queue, then into the result register, and is offered from there.
// Reset is synchronous and active high; it empties the queue and expects a method.
// req_stall rises only when the four-entry token queue is full, so a stalled
// result side backs up into the queue before it holds off new bytes.
// ---------------------------------------------------------------------------
module http_start_line_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_text_kind,
   output logic [7:0]  rsp_text_byte,
   output logic        rsp_text_end,
   output logic [3:0]  rsp_method_code,
   output logic [2:0]  rsp_version_code,
   output logic [9:0]  rsp_status_code,
   output logic        rsp_line_done,
   output logic        rsp_parse_error
);
   import hslp_pkg::*;

   // Classified bytes travel from the front end to the queue as tokens.
   logic       push;
   token_type  push_token;
   logic       queue_full;

   // The back end pops the head token whenever its result register is free or being drained.
   logic       head_valid;
   token_type  head_token;
   logic       pop;

   // The front end only decodes the byte; the queue absorbs short stalls of
   // the result side so that new transactions keep flowing.
   hslp_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_data_byte (req_data_byte),
      .queue_full    (queue_full),
      .push          (push),
      .push_token    (push_token)
   );

   hslp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_token (head_token)
   );

   // The back end owns the message type register; a new type takes effect at
   // the next restart command, and it also decides how a matched version ends.
   hslp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .tok_valid        (head_valid),
      .tok              (head_token),
      .tok_pop          (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_text_kind    (rsp_text_kind),
      .rsp_text_byte    (rsp_text_byte),
      .rsp_text_end     (rsp_text_end),
      .rsp_method_code  (rsp_method_code),
      .rsp_version_code (rsp_version_code),
      .rsp_status_code  (rsp_status_code),
      .rsp_line_done    (rsp_line_done),
      .rsp_parse_error  (rsp_parse_error)
   );

endmodule
